>>> design/bth_pkg.sv
// shared constants and helpers for the boundary tag heap allocator
`default_nettype none
package bth_pkg;

  // width of word index and word size arithmetic (holds heap end plus a block size)
  localparam int WW = 14;

  localparam int DEF_HEAP_WORDS = 4096;

  // flag bits of a header or footer word
  localparam logic [2:0] FL_RIGHT = 3'b001;
  localparam logic [2:0] FL_CUR   = 3'b010;
  localparam logic [2:0] FL_LEFT  = 3'b100;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_LARGE = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;

  // request commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // block size in words taken from a tag word
  function automatic logic [WW-1:0] sz_w(input logic [15:0] w);
    return {1'b0, w[15:3]};
  endfunction

  // tag word from a size in words and flags
  function automatic logic [15:0] tag_w(input logic [WW-1:0] s, input logic [2:0] f);
    return {s[12:0], f};
  endfunction

endpackage
`default_nettype wire

>>> design/bth_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module bth_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/boundary_tag_heap_allocator_unit.sv
// top level of the boundary tag heap allocator: sequencer around one heap ram
//
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------------------
// request  | in_valid, in_stall | cmd, req_size, addr
// result   | out_valid,out_stall| status, payload_addr, granted_size
//
// one request in flight; in_stall is high from acceptance until the result is
// loaded into the output register, so a new request may enter while that
// result still waits. through the ram read port the allocate walk reads each tag
// word in a read and a check state, and the free walk in a test, a read and a
// next state, so a request costs that per block walked plus the tag updates.
// after reset the block writes the header and footer of the single free block
// before it takes a request. a stalled result holds in the output register.
`default_nettype none
module boundary_tag_heap_allocator_unit #(
  parameter int HEAP_WORDS = bth_pkg::DEF_HEAP_WORDS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [15:0] req_size,
  input  wire logic [14:0] addr,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [14:0]      payload_addr,
  output logic [15:0]      granted_size
);

  localparam int WW = bth_pkg::WW;
  localparam int AW = $clog2(HEAP_WORDS);
  localparam logic [WW-1:0] HW = WW'(HEAP_WORDS);
  localparam logic [15:0] FULL_TAG = 16'(HEAP_WORDS * 8) | 16'd5;

  // sequencer states
  localparam logic [4:0] S_INIT0   = 5'd0;
  localparam logic [4:0] S_INIT1   = 5'd1;
  localparam logic [4:0] S_IDLE    = 5'd2;
  localparam logic [4:0] S_FIN     = 5'd3;
  localparam logic [4:0] S_A_RD    = 5'd4;
  localparam logic [4:0] S_A_CHK   = 5'd5;
  localparam logic [4:0] S_A_WR1   = 5'd6;
  localparam logic [4:0] S_A_WR2   = 5'd7;
  localparam logic [4:0] S_A_WR3   = 5'd8;
  localparam logic [4:0] S_A_WR4   = 5'd9;
  localparam logic [4:0] S_LE      = 5'd10;
  localparam logic [4:0] S_L_RD    = 5'd11;
  localparam logic [4:0] S_L_CHK   = 5'd12;
  localparam logic [4:0] S_E_RD    = 5'd13;
  localparam logic [4:0] S_E_USE   = 5'd14;
  localparam logic [4:0] S_E_FT    = 5'd15;
  localparam logic [4:0] S_F_TEST  = 5'd16;
  localparam logic [4:0] S_F_RD    = 5'd17;
  localparam logic [4:0] S_F_NXT   = 5'd18;
  localparam logic [4:0] S_F_HRD   = 5'd19;
  localparam logic [4:0] S_F_HCHK  = 5'd20;
  localparam logic [4:0] S_FL_RD   = 5'd21;
  localparam logic [4:0] S_FL_CHK  = 5'd22;
  localparam logic [4:0] S_FL2_RD  = 5'd23;
  localparam logic [4:0] S_FL2_CHK = 5'd24;
  localparam logic [4:0] S_F_RIGHT = 5'd25;
  localparam logic [4:0] S_FR_RD   = 5'd26;
  localparam logic [4:0] S_FR_CHK  = 5'd27;
  localparam logic [4:0] S_F_PUT   = 5'd28;
  localparam logic [4:0] S_F_PUT2  = 5'd29;
  localparam logic [4:0] S_F_END   = 5'd30;

  logic [4:0]    st;
  logic [4:0]    e_ret;      // where the flag edit returns
  logic [4:0]    l_ret;      // where the left neighbour step returns
  logic          cmd_q;
  logic [WW-1:0] asz;        // rounded allocate size in words
  logic [WW-1:0] h;          // walk position
  logic [WW-1:0] tgt;        // header index a free aims at
  logic [WW-1:0] b;          // block whose left neighbour gets its flag fixed
  logic [WW-1:0] start;      // merged block start
  logic [WW-1:0] total;      // merged block size in words
  logic [2:0]    flags;      // merged block flags
  logic [15:0]   w_q;        // header of the block being worked on
  logic [WW-1:0] rd_idx;     // ram read index, also the edit target
  logic [2:0]    e_mask;
  logic [15:0]   e_val;
  logic [1:0]    res_st;
  logic [14:0]   res_pa;
  logic [15:0]   res_gs;

  logic [15:0]   rdata;
  logic          wr_want;
  logic [WW-1:0] wr_idx;
  logic [15:0]   wr_val;

  // derived values
  logic [WW-1:0] r_sz;       // size field of the word just read
  logic [WW-1:0] hs;         // walk position plus that size
  logic [WW-1:0] bsz;        // size of the chosen free block
  logic [WW-1:0] rem;        // words left over after the grant
  logic          split;
  logic [WW-1:0] req_w;
  logic [2:0]    e_flags;

  always_comb begin
    r_sz    = bth_pkg::sz_w(rdata);
    hs      = h + r_sz;
    bsz     = bth_pkg::sz_w(w_q);
    rem     = bsz - asz;
    split   = rem > WW'(2);
    req_w   = WW'((17'(req_size) + 17'd23) >> 3);
    e_flags = (cmd_q == bth_pkg::CMD_FREE) ? (rdata[2:0] & ~e_mask) : (rdata[2:0] | e_mask);
  end

  // ram write port: one tag word per cycle
  always_comb begin
    wr_want = 1'b0;
    wr_idx  = '0;
    wr_val  = '0;
    case (st)
      S_INIT0: begin
        wr_want = 1'b1;
        wr_val  = FULL_TAG;
      end
      S_INIT1: begin
        wr_want = 1'b1;
        wr_idx  = HW - WW'(1);
        wr_val  = FULL_TAG;
      end
      S_A_WR1, S_A_WR2: begin
        wr_want = 1'b1;
        // granted block header and footer
        if (split) begin
          wr_val = bth_pkg::tag_w(asz, bth_pkg::FL_CUR | (w_q[2:0] & bth_pkg::FL_LEFT));
          wr_idx = (st == S_A_WR1) ? h : h + asz - WW'(1);
        end else begin
          wr_val = bth_pkg::tag_w(bsz, bth_pkg::FL_CUR | (w_q[2:0] & 3'b101));
          wr_idx = (st == S_A_WR1) ? h : h + bsz - WW'(1);
        end
      end
      S_A_WR3, S_A_WR4: begin
        // remainder block after a split
        wr_want = 1'b1;
        wr_val  = bth_pkg::tag_w(rem, bth_pkg::FL_LEFT | (w_q[2:0] & bth_pkg::FL_RIGHT));
        wr_idx  = (st == S_A_WR3) ? h + asz : h + bsz - WW'(1);
      end
      S_E_USE: begin
        wr_want = 1'b1;
        wr_idx  = rd_idx;
        wr_val  = {rdata[15:3], e_flags};
      end
      S_E_FT: begin
        wr_want = bth_pkg::sz_w(e_val) != '0;
        wr_idx  = rd_idx + bth_pkg::sz_w(e_val) - WW'(1);
        wr_val  = e_val;
      end
      S_F_PUT, S_F_PUT2: begin
        wr_want = (st == S_F_PUT) || (total != '0);
        wr_idx  = (st == S_F_PUT) ? start : start + total - WW'(1);
        wr_val  = bth_pkg::tag_w(total, flags);
      end
      default: begin
        wr_want = 1'b0;
      end
    endcase
  end

  bth_ram #(
    .WIDTH (16),
    .DEPTH (HEAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_want && (wr_idx < HW)),
    .waddr (wr_idx[AW-1:0]),
    .wdata (wr_val),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  assign in_stall = (st != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_INIT0;
      out_valid <= 1'b0;
    end else begin
      // result taken; the final state reloads the register on its own
      if (out_valid && !out_stall && st != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_INIT0: st <= S_INIT1;
        S_INIT1: st <= S_IDLE;
        S_IDLE: begin
          if (in_valid) begin
            cmd_q  <= cmd;
            res_st <= bth_pkg::ST_DONE;
            res_pa <= '0;
            res_gs <= '0;
            h      <= '0;
            rd_idx <= '0;
            if (cmd == bth_pkg::CMD_ALLOC) begin
              asz <= req_w;
              if (req_w > HW) begin
                res_st <= bth_pkg::ST_LARGE;
                st     <= S_FIN;
              end else begin
                st <= S_A_RD;
              end
            end else if (addr == '0 || addr[2:0] != 3'd0) begin
              res_st <= bth_pkg::ST_NOFIT;
              st     <= S_FIN;
            end else begin
              tgt <= WW'(addr[14:3]) - WW'(1);
              st  <= S_F_TEST;
            end
          end
        end
        S_FIN: begin
          // load the output register once it is free
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= res_st;
            payload_addr <= res_pa;
            granted_size <= res_gs;
            st           <= S_IDLE;
          end
        end
        // allocate: first fit walk
        S_A_RD: st <= S_A_CHK;
        S_A_CHK: begin
          if (!rdata[1] && r_sz >= asz) begin
            w_q <= rdata;
            b   <= h;
            st  <= S_A_WR1;
          end else if (r_sz == '0 || hs >= HW) begin
            res_st <= bth_pkg::ST_NOFIT;
            st     <= S_FIN;
          end else begin
            h      <= hs;
            rd_idx <= hs;
            st     <= S_A_RD;
          end
        end
        S_A_WR1: begin
          res_pa <= 15'({h + WW'(1), 3'b000});
          res_gs <= split ? 16'({asz, 3'b000}) : 16'({bsz, 3'b000});
          l_ret  <= S_FIN;
          st     <= S_A_WR2;
        end
        S_A_WR2: begin
          if (split) begin
            st <= S_A_WR3;
          end else if (h + bsz < HW) begin
            // right neighbour now sees an allocated left side
            rd_idx <= h + bsz;
            e_mask <= bth_pkg::FL_LEFT;
            e_ret  <= S_LE;
            st     <= S_E_RD;
          end else begin
            st <= S_LE;
          end
        end
        S_A_WR3: st <= S_A_WR4;
        S_A_WR4: st <= S_LE;
        // left neighbour flag fix, shared by both commands
        S_LE: begin
          if (b != '0) begin
            rd_idx <= b - WW'(1);
            st     <= S_L_RD;
          end else begin
            st <= l_ret;
          end
        end
        S_L_RD: st <= S_L_CHK;
        S_L_CHK: begin
          if (r_sz != '0 && r_sz <= b) begin
            rd_idx <= b - r_sz;
            e_mask <= bth_pkg::FL_RIGHT;
            e_ret  <= l_ret;
            st     <= S_E_RD;
          end else begin
            st <= l_ret;
          end
        end
        // flag edit of the block at rd_idx
        S_E_RD: st <= S_E_USE;
        S_E_USE: begin
          e_val <= {rdata[15:3], e_flags};
          st    <= S_E_FT;
        end
        S_E_FT: st <= e_ret;
        // free: walk to the target header
        S_F_TEST: begin
          if (h < tgt) begin
            rd_idx <= h;
            st     <= S_F_RD;
          end else if (h != tgt || h >= HW) begin
            res_st <= bth_pkg::ST_NOFIT;
            st     <= S_FIN;
          end else begin
            rd_idx <= h;
            st     <= S_F_HRD;
          end
        end
        S_F_RD: st <= S_F_NXT;
        S_F_NXT: begin
          h  <= (r_sz == '0 || hs > HW) ? HW + WW'(1) : hs;
          st <= S_F_TEST;
        end
        S_F_HRD: st <= S_F_HCHK;
        S_F_HCHK: begin
          if (!rdata[1]) begin
            res_st <= bth_pkg::ST_NOFIT;
            st     <= S_FIN;
          end else begin
            w_q   <= rdata;
            start <= h;
            total <= r_sz;
            flags <= rdata[2:0] & 3'b101;
            if (!rdata[2] && h != '0) begin
              rd_idx <= h - WW'(1);
              st     <= S_FL_RD;
            end else begin
              st <= S_F_RIGHT;
            end
          end
        end
        S_FL_RD: st <= S_FL_CHK;
        S_FL_CHK: begin
          // merge with a free left neighbour
          if (r_sz != '0 && r_sz <= h) begin
            start  <= h - r_sz;
            total  <= total + r_sz;
            rd_idx <= h - r_sz;
            st     <= S_FL2_RD;
          end else begin
            st <= S_F_RIGHT;
          end
        end
        S_FL2_RD: st <= S_FL2_CHK;
        S_FL2_CHK: begin
          flags[2] <= rdata[2];
          st       <= S_F_RIGHT;
        end
        S_F_RIGHT: begin
          if (!w_q[0] && (h + bsz) < HW) begin
            rd_idx <= h + bsz;
            st     <= S_FR_RD;
          end else begin
            st <= S_F_PUT;
          end
        end
        S_FR_RD: st <= S_FR_CHK;
        S_FR_CHK: begin
          // merge with a free right neighbour
          if (r_sz != '0 && rd_idx + r_sz <= HW) begin
            total    <= total + r_sz;
            flags[0] <= rdata[0];
          end
          st <= S_F_PUT;
        end
        S_F_PUT: begin
          b     <= start;
          l_ret <= S_F_END;
          st    <= S_F_PUT2;
        end
        S_F_PUT2: st <= S_LE;
        S_F_END: begin
          if (start + total < HW) begin
            rd_idx <= start + total;
            e_mask <= bth_pkg::FL_LEFT;
            e_ret  <= S_FIN;
            st     <= S_E_RD;
          end else begin
            st <= S_FIN;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/bth_chk.sv
// port level checker for the boundary tag heap allocator, with its bind
`default_nettype none
module bth_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [14:0] payload_addr,
  input wire logic [15:0] granted_size
);

  // a failed request grants nothing
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bth_pkg::ST_DONE |-> payload_addr == '0 && granted_size == '0)
    else $error("failed request carries a grant");

  // a grant covers at least header and footer and is word aligned
  a_grant_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted_size != '0 |-> granted_size >= 16'd16 && granted_size[2:0] == 3'd0)
    else $error("bad granted size");

  // payload offsets are word aligned
  a_pa_align: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> payload_addr[2:0] == 3'd0)
    else $error("unaligned payload offset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(payload_addr)
      && $stable(granted_size))
    else $error("stalled result changed");

endmodule

bind boundary_tag_heap_allocator_unit bth_chk u_bth_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .payload_addr (payload_addr),
  .granted_size (granted_size)
);
`default_nettype wire
